// ----- rtl/core/skt_pkg.sv -----
// Shared types and constants for the sorted key table search block.
`default_nettype none

package skt_pkg;

  // Field widths of one table entry and of the lookup result.
  localparam int KEY_W     = 64;
  localparam int PAYLOAD_W = 64;
  localparam int MOVE_W    = 16;
  localparam int BYTE_W    = 8;
  localparam int FLAGS_W   = 16;
  localparam int INDEX_W   = 12;
  localparam int COUNT_W   = 13;

  // Action codes carried on the request channel.
  localparam logic ACTION_LOAD   = 1'b0;
  localparam logic ACTION_LOOKUP = 1'b1;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_COMPARE,
    ST_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // write the accepted entry into the table
    logic start;     // latch the key and open the search range
    logic probe;     // read the entry at the middle of the range
    logic compare;   // compare the read key and narrow the range
    logic out_load;  // move the search result into the output register
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_empty;
    logic key_hit;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/skt_req_if.sv -----
// Request channel: load or lookup items with valid/ready handshake.
`default_nettype none

interface skt_req_if;
  import skt_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 action;
  logic [INDEX_W-1:0]   entry_index;
  logic [KEY_W-1:0]     search_key;
  logic [MOVE_W-1:0]    best_move_in;
  logic [MOVE_W-1:0]    ponder_move_in;
  logic [BYTE_W-1:0]    mate_distance_in;
  logic [BYTE_W-1:0]    morse_index_in;
  logic [FLAGS_W-1:0]   flags_in;

  modport source (
    output valid, action, entry_index, search_key, best_move_in, ponder_move_in,
           mate_distance_in, morse_index_in, flags_in,
    input  ready
  );

  modport sink (
    input  valid, action, entry_index, search_key, best_move_in, ponder_move_in,
           mate_distance_in, morse_index_in, flags_in,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/skt_rsp_if.sv -----
// Response channel: lookup results with valid/ready handshake.
`default_nettype none

interface skt_rsp_if;
  import skt_pkg::*;

  logic               valid;
  logic               ready;
  logic               found;
  logic [MOVE_W-1:0]  best_move_out;
  logic [MOVE_W-1:0]  ponder_move_out;
  logic [BYTE_W-1:0]  mate_distance_out;
  logic [BYTE_W-1:0]  morse_index_out;
  logic [FLAGS_W-1:0] flags_out;

  modport source (
    output valid, found, best_move_out, ponder_move_out, mate_distance_out,
           morse_index_out, flags_out,
    input  ready
  );

  modport sink (
    input  valid, found, best_move_out, ponder_move_out, mate_distance_out,
           morse_index_out, flags_out,
    output ready
  );
endinterface

`default_nettype wire

// ----- rtl/core/skt_ctrl.sv -----
// Controller state machine that sequences loads and binary-search lookups.
`default_nettype none

module skt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  input  wire logic               in_action,
  output logic                    in_ready,
  output logic                    out_valid,
  input  wire logic               out_ready,
  input  wire skt_pkg::dp_status_t status,
  output skt_pkg::ctrl_cmd_t      cmd
);
  import skt_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next     = state;
    cmd            = '0;
    in_ready       = 1'b0;
    out_valid_next = out_valid && !out_ready;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_action == ACTION_LOAD) begin
            cmd.load = 1'b1;
          end else begin
            cmd.start  = 1'b1;
            state_next = ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (status.range_empty) begin
          state_next = ST_DONE;
        end else begin
          cmd.probe  = 1'b1;
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = status.key_hit ? ST_DONE : ST_PROBE;
      end
      ST_DONE: begin
        // Hand the result over once the output register is free.
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/skt_datapath.sv -----
// Datapath: entry memory, search range registers, comparator and result registers.
`default_nettype none

module skt_datapath #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [skt_pkg::COUNT_W-1:0]  cfg_wdata,
  input  wire skt_pkg::ctrl_cmd_t           cmd,
  output skt_pkg::dp_status_t               status,
  input  wire logic [skt_pkg::INDEX_W-1:0]  entry_index,
  input  wire logic [skt_pkg::KEY_W-1:0]    search_key,
  input  wire logic [skt_pkg::MOVE_W-1:0]   best_move_in,
  input  wire logic [skt_pkg::MOVE_W-1:0]   ponder_move_in,
  input  wire logic [skt_pkg::BYTE_W-1:0]   mate_distance_in,
  input  wire logic [skt_pkg::BYTE_W-1:0]   morse_index_in,
  input  wire logic [skt_pkg::FLAGS_W-1:0]  flags_in,
  output logic                              found,
  output logic [skt_pkg::MOVE_W-1:0]        best_move_out,
  output logic [skt_pkg::MOVE_W-1:0]        ponder_move_out,
  output logic [skt_pkg::BYTE_W-1:0]        mate_distance_out,
  output logic [skt_pkg::BYTE_W-1:0]        morse_index_out,
  output logic [skt_pkg::FLAGS_W-1:0]       flags_out
);
  import skt_pkg::*;

  localparam int AW      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW      = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W = KEY_W + PAYLOAD_W;

  logic [ENTRY_W-1:0]   entry_mem [TABLE_DEPTH];
  logic [ENTRY_W-1:0]   rd_data;
  logic [KEY_W-1:0]     rd_key;
  logic [PAYLOAD_W-1:0] rd_payload;
  logic [COUNT_W-1:0]   entry_count;
  logic [CW-1:0]        count_sat;
  logic [KEY_W-1:0]     key_reg;
  logic [CW-1:0]        low;
  logic [CW-1:0]        high_ex;
  logic [CW-1:0]        mid;
  logic                 res_found;
  logic [PAYLOAD_W-1:0] res_payload;
  logic                 mem_we;
  logic [PAYLOAD_W-1:0] wr_payload;

  // Entry count register.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  // A count beyond the table depth searches the whole table.
  always_comb begin
    if (32'(entry_count) > 32'(TABLE_DEPTH)) begin
      count_sat = CW'(TABLE_DEPTH);
    end else begin
      count_sat = CW'(entry_count);
    end
  end

  // Loads beyond the table depth are dropped.
  assign mem_we     = cmd.load && (32'(entry_index) < 32'(TABLE_DEPTH));
  assign wr_payload = {flags_in, morse_index_in, mate_distance_in, ponder_move_in,
                       best_move_in};

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[AW'(entry_index)] <= {wr_payload, search_key};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.probe) begin
      rd_data <= entry_mem[mid[AW-1:0]];
    end
  end

  assign rd_key     = rd_data[KEY_W-1:0];
  assign rd_payload = rd_data[ENTRY_W-1:KEY_W];

  // The range is [low, high_ex); mid matches the lower middle of the inclusive range.
  assign mid = low + ((high_ex - low - CW'(1)) >> 1);

  assign status.range_empty = !(low < high_ex);
  assign status.key_hit     = (rd_key == key_reg);

  // Search range, key and result registers.
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_reg     <= search_key;
      low         <= '0;
      high_ex     <= count_sat;
      res_found   <= 1'b0;
      res_payload <= '0;
    end else if (cmd.compare) begin
      if (rd_key == key_reg) begin
        res_found   <= 1'b1;
        res_payload <= rd_payload;
      end else if (rd_key < key_reg) begin
        low <= mid + CW'(1);
      end else begin
        high_ex <= mid;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      found             <= res_found;
      best_move_out     <= res_payload[15:0];
      ponder_move_out   <= res_payload[31:16];
      mate_distance_out <= res_payload[39:32];
      morse_index_out   <= res_payload[47:40];
      flags_out         <= res_payload[63:48];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sorted_key_table_binary_search.sv -----
// Top level of the sorted key table with binary-search lookup.
`default_nettype none

// The table holds TABLE_DEPTH entries of a 64-bit key and a 64-bit payload in
// one single-port-read memory. A load transfer writes one entry; loads at an
// index at or beyond TABLE_DEPTH are dropped. A lookup transfer searches the
// first entry_count entries, which software keeps in ascending key order, and
// returns one result transfer. Each halving step is a registered memory read
// followed by a 64-bit compare. A lookup makes at most ceil(log2(entry_count
// + 1)) probes. A finished result waits in an output register, and the next
// request is accepted while it waits. Reads of entries never loaded return
// undefined data. The user must write entry_count only while no lookup is in
// flight; the block itself does not enforce this.
module sorted_key_table_binary_search #(
  parameter int TABLE_DEPTH = 4096
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        cfg_we,
  input  wire logic [skt_pkg::COUNT_W-1:0] cfg_wdata,
  skt_req_if.sink                          req,
  skt_rsp_if.source                        rsp
);
  import skt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Sequencer for loads, probes and result handoff.
  skt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_action (req.action),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Table memory and search datapath.
  skt_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .cmd               (cmd),
    .status            (status),
    .entry_index       (req.entry_index),
    .search_key        (req.search_key),
    .best_move_in      (req.best_move_in),
    .ponder_move_in    (req.ponder_move_in),
    .mate_distance_in  (req.mate_distance_in),
    .morse_index_in    (req.morse_index_in),
    .flags_in          (req.flags_in),
    .found             (rsp.found),
    .best_move_out     (rsp.best_move_out),
    .ponder_move_out   (rsp.ponder_move_out),
    .mate_distance_out (rsp.mate_distance_out),
    .morse_index_out   (rsp.morse_index_out),
    .flags_out         (rsp.flags_out)
  );

endmodule

`default_nettype wire
